FILE: rtl/cpt_pkg.sv
// Shared constants and types of the closest point on triangle block.
package cpt_pkg;

   parameter int COORD_BITS = 16;
   parameter int FRAC_BITS  = 16;

   typedef enum logic [2:0] {
      REGION_A  = 3'd0,
      REGION_B  = 3'd1,
      REGION_AB = 3'd2,
      REGION_C  = 3'd3,
      REGION_AC = 3'd4,
      REGION_BC = 3'd5,
      REGION_IN = 3'd6
   } region_type;

   // Sign tests on the six dot products that pick the region.
   typedef struct packed {
      logic fa;
      logic fb;
      logic fc;
      logic ab_ok;
      logic ac_ok;
      logic bc_ok;
   } flag_type;

   // Travels beside the two divider lanes.
   typedef struct packed {
      region_type region;
      logic       degen;
      logic       zero1;
      logic       one1;
      logic       zero2;
      logic       one2;
   } tag_type;

endpackage

FILE: rtl/cpt_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cpt_div #(
   parameter int NUM_BITS = 75,
   parameter int QUO_BITS = 16
) (
   input  logic                clock,
   input  logic                en,
   input  logic [NUM_BITS-1:0] rem_i,
   input  logic [NUM_BITS-1:0] den_i,
   output logic [QUO_BITS-1:0] quo_o
);

   logic [NUM_BITS-1:0] rem_ff [QUO_BITS];
   logic [NUM_BITS-1:0] den_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS];

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
      logic [NUM_BITS-1:0] rem_prev;
      logic [NUM_BITS-1:0] den_prev;
      logic [QUO_BITS-1:0] quo_prev;
      logic [NUM_BITS:0]   shl;
      logic [NUM_BITS:0]   dif;

      if (k == 0) begin : g_first
         assign rem_prev = rem_i;
         assign den_prev = den_i;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      // The remainder stays below the divisor, so the top bit of the
      // difference is the borrow.
      assign shl = {rem_prev, 1'b0};
      assign dif = shl - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= dif[NUM_BITS] ? shl[NUM_BITS-1:0] : dif[NUM_BITS-1:0];
            den_ff[k] <= den_prev;
            quo_ff[k] <= {quo_prev[QUO_BITS-2:0], ~dif[NUM_BITS]};
         end
      end
   end

   assign quo_o = quo_ff[QUO_BITS-1];

endmodule

FILE: rtl/closest_point_on_triangle.sv
// Top level of the closest point on triangle pipeline.
//
// Each beat on the req channel carries a query point P and the vertices
// A, B and C of a triangle as signed integer coordinates. The block sorts P
// into the Voronoi region of the triangle that holds its nearest point:
// vertex A, B or C, edge AB, AC or BC, or the interior. Each rsp beat gives
// that nearest point in signed fixed point with FRAC_BITS fraction bits,
// its three barycentric weights, the squared distance, the region code and
// a flag for a degenerate triangle (zero interior denominator, reported as
// vertex A).
//
// One beat is taken every cycle while the pipeline is not stalled. The
// pipeline depth grows with FRAC_BITS through the two divider lanes,
// which retire one quotient bit per stage.
// The wide cross products are split into partial products over two stages.
//
// Reset clears only the valid bits of the pipeline. When the receiver holds
// rsp_tready low with a result waiting, the whole pipeline freezes and
// req_tready falls; nothing is dropped or repeated.
module closest_point_on_triangle #(
   parameter int COORD_BITS = cpt_pkg::COORD_BITS,
   parameter int FRAC_BITS  = cpt_pkg::FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // query_x, query_y, query_z, vert_a_x, vert_a_y, vert_a_z,
   // vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z
   input  logic [((12*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // near_x, near_y, near_z, weight_a, weight_b, weight_c, dist_squared
   output logic [((3*(COORD_BITS+FRAC_BITS)+3*(FRAC_BITS+1)
                   +2*COORD_BITS+FRAC_BITS+2+7)/8)*8-1:0] rsp_tdata,
   // region, degenerate
   output logic [3:0] rsp_tuser
);

   localparam int CB  = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int QW  = CB + F;
   localparam int WW  = F + 1;
   localparam int DSW = 2*CB + F + 2;
   localparam int ODW = ((3*QW + 3*WW + DSW + 7)/8)*8;
   localparam int DFW = CB + 1;
   localparam int PDW = 2*CB + 2;
   localparam int DW  = 2*CB + 3;
   localparam int LW  = (DW + 1)/2;
   localparam int HW  = DW - LW;
   localparam int PW  = 2*DW;
   localparam int VW  = PW + 1;
   localparam int NW  = VW + 2;
   localparam int EW  = DW + 2;
   localparam int MW  = CB + WW + 1;

   // Stage numbers.
   localparam int T   = 10 + F;
   localparam int W   = T + 1;
   localparam int QP  = T + 2;
   localparam int QS  = T + 3;
   localparam int DA  = T + 4;
   localparam int SQ  = T + 5;
   localparam int OUT = T + 6;

   localparam logic [WW-1:0] ONE = {1'b1, {F{1'b0}}};

   // Operand pairs of the cross terms: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
   localparam int XI [6] = '{0, 2, 4, 0, 2, 4};
   localparam int YI [6] = '{3, 1, 1, 5, 5, 3};

   logic en;
   logic vld_ff [1:OUT];

   assign en         = ~vld_ff[OUT] | rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= OUT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= req_tvalid;
         for (int k = 2; k <= OUT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // Coordinates: P xyz, A xyz, B xyz, C xyz.
   logic signed [CB-1:0] geo_ff [1:QS][12];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 12; j++) geo_ff[1][j] <= req_tdata[j*CB +: CB];
         for (int k = 2; k <= QS; k++) geo_ff[k] <= geo_ff[k-1];
      end
   end

   // Stage 2: edge and offset vectors AB, AC, AP, BP, CP.
   logic signed [DFW-1:0] dif2_ff [5][3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dif2_ff[0][i] <= DFW'(geo_ff[1][6+i]) - DFW'(geo_ff[1][3+i]);
            dif2_ff[1][i] <= DFW'(geo_ff[1][9+i]) - DFW'(geo_ff[1][3+i]);
            dif2_ff[2][i] <= DFW'(geo_ff[1][i])   - DFW'(geo_ff[1][3+i]);
            dif2_ff[3][i] <= DFW'(geo_ff[1][i])   - DFW'(geo_ff[1][6+i]);
            dif2_ff[4][i] <= DFW'(geo_ff[1][i])   - DFW'(geo_ff[1][9+i]);
         end
      end
   end

   // Stage 3: component products of the six dot products d1..d6.
   logic signed [PDW-1:0] prd3_ff [6][3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < 3; i++) begin
               prd3_ff[k][i] <= PDW'(dif2_ff[k%2][i]) * PDW'(dif2_ff[2 + k/2][i]);
            end
         end
      end
   end

   // Stage 4: the dot products.
   logic signed [DW-1:0] dot4_ff [6];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 6; k++) begin
            dot4_ff[k] <= DW'(prd3_ff[k][0]) + DW'(prd3_ff[k][1]) + DW'(prd3_ff[k][2]);
         end
      end
   end

   // Stage 5: partial products of the cross terms, region sign tests and
   // the edge numerators and denominators.
   logic signed [DW+LW:0]   plo5_ff [6];
   logic signed [DW+HW-1:0] phi5_ff [6];
   logic signed [EW-1:0]    edg_ff [5:7][6];
   cpt_pkg::flag_type       fl_ff [5:7];
   logic signed [EW-1:0]    e5_in;
   logic signed [EW-1:0]    f5_in;

   assign e5_in = EW'(dot4_ff[3]) - EW'(dot4_ff[2]);
   assign f5_in = EW'(dot4_ff[4]) - EW'(dot4_ff[5]);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int m = 0; m < 6; m++) begin
            plo5_ff[m] <= (DW+LW+1)'(dot4_ff[XI[m]])
                        * (DW+LW+1)'($signed({1'b0, dot4_ff[YI[m]][LW-1:0]}));
            phi5_ff[m] <= (DW+HW)'(dot4_ff[XI[m]])
                        * (DW+HW)'($signed(dot4_ff[YI[m]][DW-1:LW]));
         end
         fl_ff[5].fa    <= (dot4_ff[0] <= 0) && (dot4_ff[1] <= 0);
         fl_ff[5].fb    <= (dot4_ff[2] >= 0) && (dot4_ff[3] <= dot4_ff[2]);
         fl_ff[5].fc    <= (dot4_ff[5] >= 0) && (dot4_ff[4] <= dot4_ff[5]);
         fl_ff[5].ab_ok <= (dot4_ff[0] >= 0) && (dot4_ff[2] <= 0);
         fl_ff[5].ac_ok <= (dot4_ff[1] >= 0) && (dot4_ff[5] <= 0);
         fl_ff[5].bc_ok <= !e5_in[EW-1] && !f5_in[EW-1];
         edg_ff[5][0]   <= EW'(dot4_ff[0]);
         edg_ff[5][1]   <= EW'(dot4_ff[0]) - EW'(dot4_ff[2]);
         edg_ff[5][2]   <= EW'(dot4_ff[1]);
         edg_ff[5][3]   <= EW'(dot4_ff[1]) - EW'(dot4_ff[5]);
         edg_ff[5][4]   <= e5_in;
         edg_ff[5][5]   <= f5_in;
         // Entry 5 becomes e + f from stage 6 on.
         for (int j = 0; j < 5; j++) edg_ff[6][j] <= edg_ff[5][j];
         edg_ff[6][5]   <= edg_ff[5][4] + edg_ff[5][5];
         edg_ff[7]      <= edg_ff[6];
         for (int k = 6; k <= 7; k++) fl_ff[k] <= fl_ff[k-1];
      end
   end

   // Stage 6: full cross products. Stage 7: va, vb, vc.
   logic signed [PW-1:0] prd6_ff [6];
   logic signed [VW-1:0] va7_ff;
   logic signed [VW-1:0] vb7_ff;
   logic signed [VW-1:0] vc7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int m = 0; m < 6; m++) begin
            prd6_ff[m] <= (PW'(phi5_ff[m]) <<< LW) + PW'(plo5_ff[m]);
         end
         vc7_ff <= VW'(prd6_ff[0]) - VW'(prd6_ff[1]);
         vb7_ff <= VW'(prd6_ff[2]) - VW'(prd6_ff[3]);
         va7_ff <= VW'(prd6_ff[4]) - VW'(prd6_ff[5]);
      end
   end

   // Stage 8: region and the operands of both divider lanes.
   cpt_pkg::region_type region8_in;
   cpt_pkg::region_type region8_ff;
   logic signed [NW-1:0] den8_in;
   logic signed [NW-1:0] n1_8_in;
   logic signed [NW-1:0] d1_8_in;
   logic signed [NW-1:0] n1_8_ff;
   logic signed [NW-1:0] d1_8_ff;
   logic signed [NW-1:0] n2_8_ff;
   logic signed [NW-1:0] d2_8_ff;
   cpt_pkg::flag_type    fl8;

   assign fl8     = fl_ff[7];
   assign den8_in = NW'(va7_ff) + NW'(vb7_ff) + NW'(vc7_ff);

   always_comb begin
      // A cross term at or below zero puts P outside the opposite edge.
      if (fl8.fa) begin
         region8_in = cpt_pkg::REGION_A;
      end else if (fl8.fb) begin
         region8_in = cpt_pkg::REGION_B;
      end else if ((vc7_ff <= 0) && fl8.ab_ok) begin
         region8_in = cpt_pkg::REGION_AB;
      end else if (fl8.fc) begin
         region8_in = cpt_pkg::REGION_C;
      end else if ((vb7_ff <= 0) && fl8.ac_ok) begin
         region8_in = cpt_pkg::REGION_AC;
      end else if ((va7_ff <= 0) && fl8.bc_ok) begin
         region8_in = cpt_pkg::REGION_BC;
      end else begin
         region8_in = cpt_pkg::REGION_IN;
      end
      case (region8_in)
         cpt_pkg::REGION_AB: begin
            n1_8_in = NW'(edg_ff[7][0]);
            d1_8_in = NW'(edg_ff[7][1]);
         end
         cpt_pkg::REGION_AC: begin
            n1_8_in = NW'(edg_ff[7][2]);
            d1_8_in = NW'(edg_ff[7][3]);
         end
         cpt_pkg::REGION_BC: begin
            n1_8_in = NW'(edg_ff[7][4]);
            d1_8_in = NW'(edg_ff[7][5]);
         end
         cpt_pkg::REGION_IN: begin
            n1_8_in = NW'(vb7_ff);
            d1_8_in = den8_in;
         end
         default: begin
            n1_8_in = '0;
            d1_8_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         region8_ff <= region8_in;
         n1_8_ff    <= n1_8_in;
         d1_8_ff    <= d1_8_in;
         n2_8_ff    <= NW'(vc7_ff);
         d2_8_ff    <= den8_in;
      end
   end

   // Stage 9: magnitudes and the cases that give a zero quotient.
   logic [NW-1:0]       m1n9_ff;
   logic [NW-1:0]       m1d9_ff;
   logic [NW-1:0]       m2n9_ff;
   logic [NW-1:0]       m2d9_ff;
   cpt_pkg::region_type region9_ff;
   logic                degen9_ff;
   logic                zero1_9_ff;
   logic                zero2_9_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m1n9_ff    <= n1_8_ff[NW-1] ? $unsigned(-n1_8_ff) : $unsigned(n1_8_ff);
         m1d9_ff    <= d1_8_ff[NW-1] ? $unsigned(-d1_8_ff) : $unsigned(d1_8_ff);
         m2n9_ff    <= n2_8_ff[NW-1] ? $unsigned(-n2_8_ff) : $unsigned(n2_8_ff);
         m2d9_ff    <= d2_8_ff[NW-1] ? $unsigned(-d2_8_ff) : $unsigned(d2_8_ff);
         region9_ff <= region8_ff;
         degen9_ff  <= (region8_ff == cpt_pkg::REGION_IN) && (d2_8_ff == 0);
         zero1_9_ff <= (d1_8_ff == 0) || (n1_8_ff[NW-1] != d1_8_ff[NW-1]);
         zero2_9_ff <= (d2_8_ff == 0) || (n2_8_ff[NW-1] != d2_8_ff[NW-1]);
      end
   end

   // Stage 10: a numerator at or above its denominator saturates to one.
   logic [NW-1:0]    rem1_10_ff;
   logic [NW-1:0]    den1_10_ff;
   logic [NW-1:0]    rem2_10_ff;
   logic [NW-1:0]    den2_10_ff;
   cpt_pkg::tag_type tag_ff [10:T];

   always_ff @(posedge clock) begin
      if (en) begin
         rem1_10_ff        <= m1n9_ff;
         den1_10_ff        <= m1d9_ff;
         rem2_10_ff        <= m2n9_ff;
         den2_10_ff        <= m2d9_ff;
         tag_ff[10].region <= region9_ff;
         tag_ff[10].degen  <= degen9_ff;
         tag_ff[10].zero1  <= zero1_9_ff;
         tag_ff[10].one1   <= m1n9_ff >= m1d9_ff;
         tag_ff[10].zero2  <= zero2_9_ff;
         tag_ff[10].one2   <= m2n9_ff >= m2d9_ff;
         for (int k = 11; k <= T; k++) tag_ff[k] <= tag_ff[k-1];
      end
   end

   logic [F-1:0] quo1;
   logic [F-1:0] quo2;

   cpt_div #(
      .NUM_BITS(NW),
      .QUO_BITS(F)
   ) u_div_lane1 (
      .clock(clock),
      .en   (en),
      .rem_i(rem1_10_ff),
      .den_i(den1_10_ff),
      .quo_o(quo1)
   );

   cpt_div #(
      .NUM_BITS(NW),
      .QUO_BITS(F)
   ) u_div_lane2 (
      .clock(clock),
      .en   (en),
      .rem_i(rem2_10_ff),
      .den_i(den2_10_ff),
      .quo_o(quo2)
   );

   // Weight stage.
   cpt_pkg::tag_type    tgw;
   logic [WW-1:0]       v1_in;
   logic [WW-1:0]       v2_in;
   logic [WW-1:0]       lim_in;
   logic [WW-1:0]       wcl_in;
   logic [WW-1:0]       wgt_in [3];
   logic [WW-1:0]       wgt_ff [W:OUT][3];
   cpt_pkg::region_type reg_ff [W:OUT];
   logic                dgn_ff [W:OUT];

   assign tgw = tag_ff[T];

   always_comb begin
      v1_in  = tgw.zero1 ? '0 : (tgw.one1 ? ONE : {1'b0, quo1});
      v2_in  = tgw.zero2 ? '0 : (tgw.one2 ? ONE : {1'b0, quo2});
      lim_in = ONE - v1_in;
      wcl_in = (v2_in > lim_in) ? lim_in : v2_in;
      wgt_in[0] = '0;
      wgt_in[1] = '0;
      wgt_in[2] = '0;
      case (tgw.region)
         cpt_pkg::REGION_A: wgt_in[0] = ONE;
         cpt_pkg::REGION_B: wgt_in[1] = ONE;
         cpt_pkg::REGION_AB: begin
            wgt_in[0] = lim_in;
            wgt_in[1] = v1_in;
         end
         cpt_pkg::REGION_C: wgt_in[2] = ONE;
         cpt_pkg::REGION_AC: begin
            wgt_in[0] = lim_in;
            wgt_in[2] = v1_in;
         end
         cpt_pkg::REGION_BC: begin
            wgt_in[1] = lim_in;
            wgt_in[2] = v1_in;
         end
         cpt_pkg::REGION_IN: begin
            if (tgw.degen) begin
               wgt_in[0] = ONE;
            end else begin
               wgt_in[0] = lim_in - wcl_in;
               wgt_in[1] = v1_in;
               wgt_in[2] = wcl_in;
            end
         end
         default: wgt_in[0] = ONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wgt_ff[W] <= wgt_in;
         reg_ff[W] <= tgw.region;
         dgn_ff[W] <= tgw.degen;
         for (int k = W + 1; k <= OUT; k++) begin
            wgt_ff[k] <= wgt_ff[k-1];
            reg_ff[k] <= reg_ff[k-1];
            dgn_ff[k] <= dgn_ff[k-1];
         end
      end
   end

   // Nearest point: weighted vertex products, their sum, then |P - Q|, its squares and the squared distance.
   logic signed [MW-1:0] qp_ff [3][3];
   logic signed [QW-1:0] q_ff [QS:OUT][3];
   logic [QW-1:0]        dabs_ff [3];
   logic [2*QW-1:0]      sq_ff [3];
   logic signed [QW:0]   dif_in [3];
   logic [DSW-1:0]       dist_ff;
   logic [2*QW+1:0]      dsum_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dif_in[i] = (QW+1)'($signed({geo_ff[QS][i], {F{1'b0}}})) - (QW+1)'(q_ff[QS][i]);
      end
      dsum_in = (2*QW+2)'(sq_ff[0]) + (2*QW+2)'(sq_ff[1]) + (2*QW+2)'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int v = 0; v < 3; v++) begin
               qp_ff[i][v] <= MW'(geo_ff[W][3 + 3*v + i])
                            * MW'($signed({1'b0, wgt_ff[W][v]}));
            end
            q_ff[QS][i] <= QW'((MW+2)'(qp_ff[i][0]) + (MW+2)'(qp_ff[i][1])
                              + (MW+2)'(qp_ff[i][2]));
            dabs_ff[i]  <= dif_in[i][QW] ? QW'(-dif_in[i]) : QW'(dif_in[i]);
            sq_ff[i]    <= (2*QW)'(dabs_ff[i]) * (2*QW)'(dabs_ff[i]);
         end
         for (int k = QS + 1; k <= OUT; k++) q_ff[k] <= q_ff[k-1];
         dist_ff <= DSW'(dsum_in >> F);
      end
   end

   assign rsp_tvalid = vld_ff[OUT];
   assign rsp_tdata  = ODW'({dist_ff, wgt_ff[OUT][2], wgt_ff[OUT][1], wgt_ff[OUT][0],
                             q_ff[OUT][2], q_ff[OUT][1], q_ff[OUT][0]});
   assign rsp_tuser  = {dgn_ff[OUT], reg_ff[OUT]};

   // A degenerate triangle is only ever flagged from the interior test.
   a_degen_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && dgn_ff[OUT] |-> reg_ff[OUT] == cpt_pkg::REGION_IN)
      else $error("degenerate flag outside the interior region");

   // The three weights always add up to exactly one.
   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (WW+2)'(wgt_ff[OUT][0]) + (WW+2)'(wgt_ff[OUT][1])
                     + (WW+2)'(wgt_ff[OUT][2]) == (WW+2)'(ONE))
      else $error("barycentric weights do not sum to one");

   // A vertex region puts all weight on that vertex; this check covers vertex C.
   a_vertex_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && reg_ff[OUT] == cpt_pkg::REGION_C |-> wgt_ff[OUT][2] == ONE)
      else $error("vertex C region without full C weight");

   // Nothing leaves the pipeline right after reset.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat directly after reset");

endmodule
